### design/ising_metropolis_spin_update_core_assert.svh
// Assertion macros shared by the Ising spin update core.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_CORE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ism_pkg.sv
// Package with constants, types and the exponent table of the Ising spin update core.
package ism_pkg;

    localparam int NUM_SPINS          = 128;
    localparam int SPIN_AW            = $clog2(NUM_SPINS);
    localparam int CPL_AW             = 2 * SPIN_AW;
    localparam int CPL_DEPTH          = 1 << CPL_AW;
    localparam int INDEX_W            = 7;
    localparam int CPL_W              = 16;
    localparam int DRAW_W             = 16;
    localparam int THERM_W            = 24;
    localparam int CNT_W              = 32;
    localparam int ENERGY_W           = 24;
    localparam int COUPLING_FRAC_BITS = 14;
    localparam int EXP_TABLE_DEPTH    = 4096;
    localparam int EXP_AW             = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_SHIFT          = COUPLING_FRAC_BITS - 8;
    localparam int EXP_ENTRY_W        = 17;
    localparam int H_W                = CPL_W + SPIN_AW;
    localparam int DE_W               = (H_W + 1 > ENERGY_W) ? H_W + 1 : ENERGY_W;

    localparam logic [63:0] EXP_STEP_FACTOR = 64'd4278222805;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SET    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_SET,
        ST_READ,
        ST_READ_DATA,
        ST_UPD_SELF,
        ST_UPD_SUM,
        ST_UPD_TAIL,
        ST_UPD_DE,
        ST_UPD_ROM,
        ST_UPD_DEC,
        ST_EMIT
    } state_t;

    typedef logic [EXP_ENTRY_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    // Entry k holds exp(-k/256) scaled by 65536, built by repeated multiplication.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] r;
        r = 64'h1_0000_0000;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            rom[k] = EXP_ENTRY_W'(r >> 16);
            r = (r * EXP_STEP_FACTOR + 64'h8000_0000) >> 32;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### design/ism_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ism_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ising_metropolis_spin_update_core.sv
// Top level of the Metropolis single-spin-flip Ising update core.

// Couplings live in a 16384-word RAM and spins in a 128-bit RAM, both with registered reads.
// An update step reads one coupling row and the matching spins at one word per cycle. It
// first reads the spin itself, then sweeps the row, and then does the last accumulation,
// the energy change, the exponent table lookup, the decision and the output register. A
// coupling load writes both symmetric entries. One item is worked on at a time; the core
// is ready for the next transaction in the same cycle that the previous result sits in
// the output register, even if it is not yet taken. The stores are undefined until
// written, and no clearing pass runs after reset.
`include "ising_metropolis_spin_update_core_assert.svh"

module ising_metropolis_spin_update_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ism_pkg::THERM_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [ism_pkg::INDEX_W-1:0]      spin_index,
    input  logic [ism_pkg::INDEX_W-1:0]      partner_index,
    input  logic signed [ism_pkg::CPL_W-1:0] coupling_value,
    input  logic                             spin_value,
    input  logic [ism_pkg::DRAW_W-1:0]       uniform_draw,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ism_pkg::INDEX_W-1:0]      result_spin_index,
    output logic                             new_spin,
    output logic                             flipped,
    output logic                             sample_point,
    output logic signed [ism_pkg::ENERGY_W-1:0] energy_change
);

    ism_pkg::state_t state_reg, state_next;

    logic [ism_pkg::THERM_W-1:0]  therm_reg;
    logic [ism_pkg::CNT_W-1:0]    cnt_reg;
    logic [ism_pkg::SPIN_AW-1:0]  j_reg, j_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [ism_pkg::SPIN_AW-1:0]  rd_j_reg;
    logic                         out_valid_reg;

    ism_pkg::mode_t               mode_reg;
    logic [ism_pkg::INDEX_W-1:0]  idx_reg;
    logic [ism_pkg::INDEX_W-1:0]  part_reg;
    logic [ism_pkg::CPL_W-1:0]    cpl_reg;
    logic                         sval_reg;
    logic [ism_pkg::DRAW_W-1:0]   draw_reg;
    logic                         self_reg;
    logic signed [ism_pkg::H_W-1:0]  h_reg;
    logic signed [ism_pkg::DE_W-1:0] de_reg;
    logic [ism_pkg::EXP_ENTRY_W-1:0] exp_data_reg;

    logic                         res_spin_reg;
    logic                         res_flip_reg;
    logic                         res_sample_reg;
    logic [ism_pkg::ENERGY_W-1:0] res_de_reg;

    logic [ism_pkg::INDEX_W-1:0]  out_idx_reg;
    logic                         out_spin_reg;
    logic                         out_flip_reg;
    logic                         out_sample_reg;
    logic [ism_pkg::ENERGY_W-1:0] out_de_reg;

    logic                         spin_we;
    logic [ism_pkg::SPIN_AW-1:0]  spin_waddr;
    logic                         spin_wdata;
    logic [ism_pkg::SPIN_AW-1:0]  spin_raddr;
    logic                         spin_rdata;
    logic                         cpl_we;
    logic [ism_pkg::CPL_AW-1:0]   cpl_waddr;
    logic [ism_pkg::CPL_W-1:0]    cpl_rdata;

    logic                         in_fire;
    logic                         in_range;
    logic                         emit_fire;
    logic [ism_pkg::SPIN_AW-1:0]  row_addr;
    logic [ism_pkg::SPIN_AW-1:0]  col_addr;
    logic signed [ism_pkg::H_W-1:0]  cpl_ext;
    logic signed [ism_pkg::DE_W-1:0] h_ext;
    logic signed [ism_pkg::DE_W-1:0] de_calc;
    logic [ism_pkg::EXP_AW-1:0]   rom_addr;
    logic                         de_nonpos;
    logic                         rom_hit;
    logic                         upd_accept;
    logic                         upd_sample;
    logic [ism_pkg::ENERGY_W-1:0] de_sat;

    localparam logic signed [ism_pkg::DE_W-1:0] DeMax =
        ism_pkg::DE_W'((1 << (ism_pkg::ENERGY_W - 1)) - 1);
    localparam logic signed [ism_pkg::DE_W-1:0] DeMin =
        ism_pkg::DE_W'(-(1 << (ism_pkg::ENERGY_W - 1)));

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ism_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (state_reg == ism_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    assign in_range = (32'(spin_index) < 32'(ism_pkg::NUM_SPINS)) &&
                      ((ism_pkg::mode_t'(mode) != ism_pkg::MODE_LOAD) ||
                       (32'(partner_index) < 32'(ism_pkg::NUM_SPINS)));

    assign row_addr = idx_reg[ism_pkg::SPIN_AW-1:0];
    assign col_addr = part_reg[ism_pkg::SPIN_AW-1:0];

    assign cpl_ext = {{(ism_pkg::H_W - ism_pkg::CPL_W){cpl_rdata[ism_pkg::CPL_W-1]}},
                      cpl_rdata};
    assign h_ext   = {{(ism_pkg::DE_W - ism_pkg::H_W){h_reg[ism_pkg::H_W-1]}}, h_reg};
    assign de_calc = self_reg ? (h_ext <<< 1) : -(h_ext <<< 1);

    assign rom_addr  = de_reg[ism_pkg::EXP_SHIFT +: ism_pkg::EXP_AW];
    assign de_nonpos = de_reg[ism_pkg::DE_W-1] || (de_reg == '0);
    assign rom_hit   = (de_reg[ism_pkg::DE_W-1:ism_pkg::EXP_SHIFT+ism_pkg::EXP_AW] == '0) &&
                       (exp_data_reg > ism_pkg::EXP_ENTRY_W'(draw_reg));
    assign upd_accept = de_nonpos || rom_hit;
    assign upd_sample = (cnt_reg[ism_pkg::SPIN_AW-1:0] == '0) &&
                        (cnt_reg >= ism_pkg::CNT_W'(therm_reg));

    always_comb
    begin
        if (de_reg > DeMax)
        begin
            de_sat = DeMax[ism_pkg::ENERGY_W-1:0];
        end
        else if (de_reg < DeMin)
        begin
            de_sat = DeMin[ism_pkg::ENERGY_W-1:0];
        end
        else
        begin
            de_sat = de_reg[ism_pkg::ENERGY_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        rd_vld_next = 1'b0;
        spin_we     = 1'b0;
        spin_waddr  = row_addr;
        spin_wdata  = sval_reg;
        spin_raddr  = row_addr;
        cpl_we      = 1'b0;
        cpl_waddr   = {row_addr, col_addr};
        case (state_reg)
            ism_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_range)
                    begin
                        state_next = ism_pkg::ST_EMIT;
                    end
                    else
                    begin
                        case (ism_pkg::mode_t'(mode))
                            ism_pkg::MODE_LOAD:   state_next = ism_pkg::ST_LOAD_A;
                            ism_pkg::MODE_SET:    state_next = ism_pkg::ST_SET;
                            ism_pkg::MODE_UPDATE: state_next = ism_pkg::ST_UPD_SELF;
                            ism_pkg::MODE_READ:   state_next = ism_pkg::ST_READ;
                            default:              state_next = ism_pkg::ST_EMIT;
                        endcase
                    end
                end
            end
            ism_pkg::ST_LOAD_A:
            begin
                cpl_we     = 1'b1;
                state_next = ism_pkg::ST_LOAD_B;
            end
            ism_pkg::ST_LOAD_B:
            begin
                cpl_we     = 1'b1;
                cpl_waddr  = {col_addr, row_addr};
                state_next = ism_pkg::ST_EMIT;
            end
            ism_pkg::ST_SET:
            begin
                spin_we    = 1'b1;
                state_next = ism_pkg::ST_EMIT;
            end
            ism_pkg::ST_READ:
            begin
                state_next = ism_pkg::ST_READ_DATA;
            end
            ism_pkg::ST_READ_DATA:
            begin
                state_next = ism_pkg::ST_EMIT;
            end
            ism_pkg::ST_UPD_SELF:
            begin
                j_next     = '0;
                state_next = ism_pkg::ST_UPD_SUM;
            end
            ism_pkg::ST_UPD_SUM:
            begin
                spin_raddr  = j_reg;
                rd_vld_next = 1'b1;
                j_next      = j_reg + 1'b1;
                if (j_reg == ism_pkg::SPIN_AW'(ism_pkg::NUM_SPINS - 1))
                begin
                    state_next = ism_pkg::ST_UPD_TAIL;
                end
            end
            ism_pkg::ST_UPD_TAIL:
            begin
                state_next = ism_pkg::ST_UPD_DE;
            end
            ism_pkg::ST_UPD_DE:
            begin
                state_next = ism_pkg::ST_UPD_ROM;
            end
            ism_pkg::ST_UPD_ROM:
            begin
                state_next = ism_pkg::ST_UPD_DEC;
            end
            ism_pkg::ST_UPD_DEC:
            begin
                spin_we    = 1'b1;
                spin_wdata = self_reg ^ upd_accept;
                state_next = ism_pkg::ST_EMIT;
            end
            ism_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ism_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ism_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ism_pkg::ST_IDLE;
            therm_reg     <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            rd_vld_reg <= rd_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                therm_reg <= cfg_data;
            end
            if (state_reg == ism_pkg::ST_UPD_DEC)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_j_reg     <= j_reg;
        exp_data_reg <= ism_pkg::EXP_ROM[rom_addr];
        if (in_fire)
        begin
            mode_reg       <= ism_pkg::mode_t'(mode);
            idx_reg        <= spin_index;
            part_reg       <= partner_index;
            cpl_reg        <= coupling_value;
            sval_reg       <= spin_value;
            draw_reg       <= uniform_draw;
            res_spin_reg   <= 1'b0;
            res_flip_reg   <= 1'b0;
            res_sample_reg <= 1'b0;
            res_de_reg     <= '0;
        end
        if (state_reg == ism_pkg::ST_UPD_SELF)
        begin
            h_reg <= '0;
        end
        else if (rd_vld_reg && (rd_j_reg != row_addr))
        begin
            h_reg <= spin_rdata ? (h_reg + cpl_ext) : (h_reg - cpl_ext);
        end
        if ((state_reg == ism_pkg::ST_UPD_SUM) && (j_reg == '0))
        begin
            self_reg <= spin_rdata;
        end
        if (state_reg == ism_pkg::ST_UPD_DE)
        begin
            de_reg <= de_calc;
        end
        case (state_reg)
            ism_pkg::ST_LOAD_B:    res_spin_reg <= spin_rdata;
            ism_pkg::ST_SET:       res_spin_reg <= sval_reg;
            ism_pkg::ST_READ_DATA: res_spin_reg <= spin_rdata;
            ism_pkg::ST_UPD_DEC:
            begin
                res_spin_reg   <= self_reg ^ upd_accept;
                res_flip_reg   <= upd_accept;
                res_sample_reg <= upd_sample;
                res_de_reg     <= de_sat;
            end
            default:
            begin
            end
        endcase
        if (emit_fire)
        begin
            out_idx_reg    <= idx_reg;
            out_spin_reg   <= res_spin_reg;
            out_flip_reg   <= res_flip_reg;
            out_sample_reg <= res_sample_reg;
            out_de_reg     <= res_de_reg;
        end
    end

    ism_ram #(
        .WIDTH (ism_pkg::CPL_W),
        .DEPTH (ism_pkg::CPL_DEPTH)
    ) u_cpl_ram (
        .clk   (clk),
        .we    (cpl_we),
        .waddr (cpl_waddr),
        .wdata (cpl_reg),
        .raddr ({row_addr, j_reg}),
        .rdata (cpl_rdata)
    );

    ism_ram #(
        .WIDTH (1),
        .DEPTH (ism_pkg::NUM_SPINS)
    ) u_spin_ram (
        .clk   (clk),
        .we    (spin_we),
        .waddr (spin_waddr),
        .wdata (spin_wdata),
        .raddr (spin_raddr),
        .rdata (spin_rdata)
    );

    assign out_valid         = out_valid_reg;
    assign result_spin_index = out_idx_reg;
    assign new_spin          = out_spin_reg;
    assign flipped           = out_flip_reg;
    assign sample_point      = out_sample_reg;
    assign energy_change     = out_de_reg;

    `ISM_ASSERT_IMP(a_no_spin_write_in_sum, clk, rst_n, spin_we, (state_reg != ism_pkg::ST_UPD_SUM), "spin store written during a row sweep")
    `ISM_ASSERT_NXT(a_cnt_step, clk, rst_n, (state_reg == ism_pkg::ST_UPD_DEC), (cnt_reg == $past(cnt_reg) + 1'b1), "update counter did not advance")
    `ISM_ASSERT_NXT(a_cnt_hold, clk, rst_n, (state_reg != ism_pkg::ST_UPD_DEC), $stable(cnt_reg), "update counter moved outside an update decision")
    `ISM_ASSERT_NXT(a_emit_loads, clk, rst_n, emit_fire, (out_valid && (state_reg == ism_pkg::ST_IDLE)), "result transaction not presented after emit")
    `ISM_ASSERT_IMP(a_flip_only_update, clk, rst_n, (emit_fire && res_flip_reg), (mode_reg == ism_pkg::MODE_UPDATE), "flip reported for a non-update transaction")

endmodule

### tb/tb_ising_metropolis_spin_update_core.sv
// Self-checking testbench for the Metropolis single-spin-flip Ising update core.
module tb_ising_metropolis_spin_update_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        ism_pkg::mode_t                       mode;
        logic [ism_pkg::INDEX_W-1:0]          spin;
        logic [ism_pkg::INDEX_W-1:0]          partner;
        logic signed [ism_pkg::CPL_W-1:0]     coupling;
        logic                                 sval;
        logic [ism_pkg::DRAW_W-1:0]           draw;
    } spin_item_t;

    typedef struct {
        logic [ism_pkg::INDEX_W-1:0]          spin;
        logic                                 new_spin;
        logic                                 flipped;
        logic                                 sample;
        logic signed [ism_pkg::ENERGY_W-1:0]  energy;
    } spin_outcome_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [ism_pkg::THERM_W-1:0]           cfg_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic [1:0]                            mode;
    logic [ism_pkg::INDEX_W-1:0]           spin_index;
    logic [ism_pkg::INDEX_W-1:0]           partner_index;
    logic signed [ism_pkg::CPL_W-1:0]      coupling_value;
    logic                                  spin_value;
    logic [ism_pkg::DRAW_W-1:0]            uniform_draw;
    logic                                  out_valid;
    logic                                  out_ready;
    logic [ism_pkg::INDEX_W-1:0]           result_spin_index;
    logic                                  new_spin;
    logic                                  flipped;
    logic                                  sample_point;
    logic signed [ism_pkg::ENERGY_W-1:0]   energy_change;

    logic signed [ism_pkg::CPL_W-1:0]      couplings [ism_pkg::NUM_SPINS][ism_pkg::NUM_SPINS];
    bit                                    spins [ism_pkg::NUM_SPINS];
    bit [ism_pkg::CNT_W-1:0]               update_count;
    bit [ism_pkg::THERM_W-1:0]             therm_steps;
    logic [ism_pkg::EXP_ENTRY_W-1:0]       exp_weight [ism_pkg::EXP_TABLE_DEPTH];

    spin_outcome_t                pending_outcomes [$];
    int                           gap_limit;
    int                           mismatch_count;
    int                           items_sent;
    int                           update_steps;
    int                           flips_seen;
    int                           samples_seen;
    int                           beyond_table;

    ising_metropolis_spin_update_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .spin_index        (spin_index),
        .partner_index     (partner_index),
        .coupling_value    (coupling_value),
        .spin_value        (spin_value),
        .uniform_draw      (uniform_draw),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_spin_index (result_spin_index),
        .new_spin          (new_spin),
        .flipped           (flipped),
        .sample_point      (sample_point),
        .energy_change     (energy_change)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic spin_outcome_t predict_spin_item(input spin_item_t it);
        spin_outcome_t res;
        longint        field_sum;
        longint        de;
        longint        rom_idx;
        bit            accept;
        int            i;
        i = it.spin;
        res.spin = it.spin;
        res.new_spin = 1'b0;
        res.flipped = 1'b0;
        res.sample = 1'b0;
        de = 0;
        case (it.mode)
            ism_pkg::MODE_LOAD:
            begin
                couplings[i][it.partner] = it.coupling;
                couplings[it.partner][i] = it.coupling;
                res.new_spin = spins[i];
            end
            ism_pkg::MODE_SET:
            begin
                spins[i] = it.sval;
                res.new_spin = it.sval;
            end
            ism_pkg::MODE_READ:
            begin
                res.new_spin = spins[i];
            end
            default:
            begin
                field_sum = 0;
                for (int j = 0; j < ism_pkg::NUM_SPINS; j++)
                begin
                    if (j != i)
                        field_sum += spins[j] ? longint'(couplings[i][j])
                                              : -longint'(couplings[i][j]);
                end
                de = spins[i] ? 2 * field_sum : -2 * field_sum;
                accept = 1'b1;
                if (de > 0)
                begin
                    rom_idx = de >>> ism_pkg::EXP_SHIFT;
                    if (rom_idx >= ism_pkg::EXP_TABLE_DEPTH)
                    begin
                        accept = 1'b0;
                        beyond_table++;
                    end
                    else
                        accept = exp_weight[rom_idx] > it.draw;
                end
                if (accept)
                begin
                    spins[i] = ~spins[i];
                    flips_seen++;
                end
                res.flipped = accept;
                res.new_spin = spins[i];
                res.sample = (update_count % ism_pkg::NUM_SPINS == 0) &&
                             (update_count >= therm_steps);
                if (res.sample)
                    samples_seen++;
                update_count++;
                update_steps++;
            end
        endcase
        if (de > (longint'(1) << (ism_pkg::ENERGY_W - 1)) - 1)
            de = (longint'(1) << (ism_pkg::ENERGY_W - 1)) - 1;
        if (de < -(longint'(1) << (ism_pkg::ENERGY_W - 1)))
            de = -(longint'(1) << (ism_pkg::ENERGY_W - 1));
        res.energy = ism_pkg::ENERGY_W'(de);
        return res;
    endfunction

    // Only the rows of the first two and the last two spins are loaded completely.
    function automatic bit has_full_row(input int s);
        return (s < 2) || (s >= ism_pkg::NUM_SPINS - 2);
    endfunction

    function automatic int full_row_spin();
        int k;
        k = $urandom_range(0, 3);
        return (k < 2) ? k : ism_pkg::NUM_SPINS - 4 + k;
    endfunction

    function automatic spin_item_t make_item(input ism_pkg::mode_t m, input int s,
                                             input int p, input int cpl, input bit sv,
                                             input int d);
        spin_item_t it;
        it.mode = m;
        it.spin = ism_pkg::INDEX_W'(s);
        it.partner = ism_pkg::INDEX_W'(p);
        it.coupling = ism_pkg::CPL_W'(cpl);
        it.sval = sv;
        it.draw = ism_pkg::DRAW_W'(d);
        return it;
    endfunction

    function automatic spin_item_t random_spin_item();
        spin_item_t it;
        int         pick;
        it.spin = ism_pkg::INDEX_W'($urandom_range(0, ism_pkg::NUM_SPINS - 1));
        it.partner = ism_pkg::INDEX_W'($urandom_range(0, ism_pkg::NUM_SPINS - 1));
        it.coupling = ism_pkg::CPL_W'($urandom);
        it.sval = 1'($urandom_range(0, 1));
        it.draw = ism_pkg::DRAW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            it.mode = ism_pkg::MODE_UPDATE;
            it.spin = ism_pkg::INDEX_W'(full_row_spin());
            pick = $urandom_range(0, 9);
            if (pick == 0)
                it.draw = '0;
            else if (pick == 1)
                it.draw = '1;
        end
        else if (pick < 65)
        begin
            it.mode = ism_pkg::MODE_LOAD;
            if ($urandom_range(0, 19) == 0)
                it.partner = it.spin;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                it.coupling = ism_pkg::CPL_W'(int'($urandom_range(0, 4096)) - 2048);
            else if (pick < 85)
                it.coupling = ism_pkg::CPL_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        else if (pick < 80)
            it.mode = ism_pkg::MODE_SET;
        else
            it.mode = ism_pkg::MODE_READ;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic send_item(input spin_item_t it);
        int gap;
        gap = $urandom_range(0, gap_limit);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode <= it.mode;
        spin_index <= it.spin;
        partner_index <= it.partner;
        coupling_value <= it.coupling;
        spin_value <= it.sval;
        uniform_draw <= it.draw;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        pending_outcomes.push_back(predict_spin_item(it));
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [ism_pkg::THERM_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        therm_steps = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_stores();
        gap_limit = 14;
        for (int s = 0; s < ism_pkg::NUM_SPINS; s++)
            send_item(make_item(ism_pkg::MODE_SET, s, 0, 0, 1'($urandom_range(0, 1)), 0));
        for (int r = 0; r < ism_pkg::NUM_SPINS; r++)
            for (int c = r + 1; c < ism_pkg::NUM_SPINS; c++)
                if (has_full_row(r) || has_full_row(c))
                    send_item(make_item(ism_pkg::MODE_LOAD, r, c,
                                        int'($urandom_range(0, 4096)) - 2048, 1'b0, 0));
    endtask

    task automatic check_directed_cases();
        gap_limit = 14;
        // Six strong bonds aligned with spin 0 push its flip far past the exponent table,
        // while a huge diagonal entry must have no effect on the field.
        send_item(make_item(ism_pkg::MODE_LOAD, 0, 0, -32768, 0, 0));
        for (int p = 1; p <= 5; p++)
            send_item(make_item(ism_pkg::MODE_LOAD, 0, p, 32767, 0, 0));
        send_item(make_item(ism_pkg::MODE_LOAD, 0, ism_pkg::NUM_SPINS - 1, 32767, 1, 65535));
        for (int s = 0; s <= 5; s++)
            send_item(make_item(ism_pkg::MODE_SET, s, 0, 0, 1'b1, 0));
        send_item(make_item(ism_pkg::MODE_SET, ism_pkg::NUM_SPINS - 1, 127, -1, 1'b1, 65535));
        send_item(make_item(ism_pkg::MODE_READ, 0, 127, 0, 1'b0, 0));
        send_item(make_item(ism_pkg::MODE_READ, ism_pkg::NUM_SPINS - 1, 0, 0, 1'b0, 0));
        send_item(make_item(ism_pkg::MODE_UPDATE, 0, 0, 0, 1'b0, 0));
        send_item(make_item(ism_pkg::MODE_SET, 0, 0, 0, 1'b0, 0));
        send_item(make_item(ism_pkg::MODE_UPDATE, 0, 0, 0, 1'b0, 65535));
        send_item(make_item(ism_pkg::MODE_LOAD, ism_pkg::NUM_SPINS - 1,
                            ism_pkg::NUM_SPINS - 2, 16384, 0, 0));
        send_item(make_item(ism_pkg::MODE_LOAD, ism_pkg::NUM_SPINS - 2,
                            ism_pkg::NUM_SPINS - 3, -16384, 0, 0));
        send_item(make_item(ism_pkg::MODE_UPDATE, ism_pkg::NUM_SPINS - 1, 0, 0, 1'b0, 0));
        send_item(make_item(ism_pkg::MODE_UPDATE, ism_pkg::NUM_SPINS - 1, 0, 0, 1'b0, 65535));
    endtask

    task automatic run_random_phase(input logic [ism_pkg::THERM_W-1:0] threshold,
                                    input int n_items, input int max_gap);
        write_threshold(threshold);
        gap_limit = max_gap;
        repeat (n_items)
            send_item(random_spin_item());
    endtask

    initial
    begin
        longint unsigned r;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = ism_pkg::MODE_LOAD;
        spin_index = '0;
        partner_index = '0;
        coupling_value = '0;
        spin_value = 1'b0;
        uniform_draw = '0;
        gap_limit = 14;
        rst_n = 1'b0;
        r = 64'h1_0000_0000;
        for (int k = 0; k < ism_pkg::EXP_TABLE_DEPTH; k++)
        begin
            exp_weight[k] = r[32:16];
            r = (r * ism_pkg::EXP_STEP_FACTOR + 64'h8000_0000) >> 32;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_threshold({ism_pkg::THERM_W{1'b1}});
        fill_stores();
        check_directed_cases();
        run_random_phase('0, 260, 14);
        run_random_phase(ism_pkg::THERM_W'(256), 260, 14);
        run_random_phase(ism_pkg::THERM_W'($urandom_range(1, 900)), 260, 14);
        run_random_phase({ism_pkg::THERM_W{1'b1}}, 260, 14);
        run_random_phase(ism_pkg::THERM_W'(1), 260, 14);
        drain_results();
        repeat (200) @(posedge clk);

        $display("Run covered %0d transactions, %0d update steps, %0d flips, %0d sample points.",
                 items_sent, update_steps, flips_seen, samples_seen);
        $display("%0d proposals fell beyond the exponent table; thresholds spanned 0 to max.",
                 beyond_table);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int            stall;
        spin_outcome_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, gap_limit);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (pending_outcomes.size() == 0)
                report_mismatch($sformatf("result for spin %0d with nothing pending",
                                          result_spin_index));
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_spin_index !== want.spin)
                    report_mismatch($sformatf("result_spin_index got %0d want %0d",
                                              result_spin_index, want.spin));
                if (new_spin !== want.new_spin)
                    report_mismatch($sformatf("spin %0d new_spin got %b want %b",
                                              want.spin, new_spin, want.new_spin));
                if (flipped !== want.flipped)
                    report_mismatch($sformatf("spin %0d flipped got %b want %b",
                                              want.spin, flipped, want.flipped));
                if (sample_point !== want.sample)
                    report_mismatch($sformatf("spin %0d sample_point got %b want %b",
                                              want.spin, sample_point, want.sample));
                if (energy_change !== want.energy)
                    report_mismatch($sformatf("spin %0d energy_change got %0d want %0d",
                                              want.spin, energy_change, want.energy));
            end
        end
    end

endmodule

### sim.f
+incdir+design
design/ism_pkg.sv
design/ism_ram.sv
design/ising_metropolis_spin_update_core.sv
tb/tb_ising_metropolis_spin_update_core.sv
